// ===== rtl/assert_macros.svh =====
// Assertion macros used by the calendar converter divider
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define E2C_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("e2c assertion failed");
`define E2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("e2c assertion failed");
`else
`define E2C_ASSERT(lbl, clk, rst_n, prop)
`define E2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/e2c_pkg.sv =====
// Shared constants, command/status types and tables for the calendar converter
package e2c_pkg;

    localparam int DIV_W  = 58;   // aligned dividend width
    localparam int REM_W  = 18;   // divisor / remainder width
    localparam int STEP_W = 5;    // radix-4 step count width
    localparam int OP_W   = 3;

    // divider operations, in issue order
    localparam logic [OP_W-1:0] OP_SEC    = 3'd0;
    localparam logic [OP_W-1:0] OP_DAY400 = 3'd1;
    localparam logic [OP_W-1:0] OP_WDAY   = 3'd2;
    localparam logic [OP_W-1:0] OP_C100   = 3'd3;
    localparam logic [OP_W-1:0] OP_Q4     = 3'd4;
    localparam logic [OP_W-1:0] OP_RY     = 3'd5;
    localparam logic [OP_W-1:0] OP_HOUR   = 3'd6;
    localparam logic [OP_W-1:0] OP_MIN    = 3'd7;
    localparam logic [OP_W-1:0] OP_LAST   = OP_MIN;

    localparam logic [REM_W-1:0] SEC_DAY   = 18'd86400;
    localparam logic [REM_W-1:0] DAYS_400Y = 18'd146097;
    localparam logic [REM_W-1:0] DAYS_100Y = 18'd36524;
    localparam logic [REM_W-1:0] DAYS_4Y   = 18'd1461;
    localparam logic [REM_W-1:0] DAYS_1Y   = 18'd365;
    localparam logic [REM_W-1:0] DAYS_WEEK = 18'd7;
    localparam logic [REM_W-1:0] SEC_HOUR  = 18'd3600;
    localparam logic [REM_W-1:0] SEC_MIN   = 18'd60;

    // epoch moved to 2000-03-01
    localparam logic [63:0] SHIFTED_EPOCH = 64'd946684800 + 64'd86400 * 64'd60;

    // Dividend bias: 2^23 whole 400-year cycles keeps every value non-negative.
    // 146097 is a multiple of 7, so the bias does not move the weekday.
    localparam int QC_BIAS_LOG2 = 23;
    localparam logic [63:0] BIAS_DAYS  = 64'(DAYS_400Y) << QC_BIAS_LOG2;
    localparam logic [63:0] BIAS_SECS  = BIAS_DAYS * 64'(SEC_DAY);
    localparam logic [63:0] SEC_OFFSET = BIAS_SECS - SHIFTED_EPOCH;

    localparam logic signed [63:0] T_MAX = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] T_MIN = -64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] S_MAX = 64'sd2147483647 * 64'sd31622400;
    localparam logic signed [63:0] S_MIN = -(64'sd2147483648 * 64'sd31622400);

    localparam logic signed [35:0] Y_MAX = 36'sd2147483647;
    localparam logic signed [35:0] Y_MIN = -36'sd2147483648;

    typedef struct packed {
        logic            load_in;
        logic            calc_s;
        logic            check;
        logic            div_go;
        logic            div_store;
        logic [OP_W-1:0] div_op;
        logic            calc_year;
        logic            month_step;
        logic            out_load;
    } cmd_t;

    typedef struct packed {
        logic ovf;
        logic div_done;
        logic month_done;
        logic out_free;
    } stat_t;

    // month lengths starting from March
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd6, 4'd8: len = 5'd30;
            4'd11:                  len = 5'd29;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/e2c_div.sv =====
// Shared radix-4 restoring divider, left-aligned dividend, two quotient bits per cycle
`include "assert_macros.svh"

module e2c_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [e2c_pkg::DIV_W-1:0]    dividend,
    input  logic [e2c_pkg::REM_W-1:0]    divisor,
    input  logic [e2c_pkg::STEP_W-1:0]   steps,
    output logic [e2c_pkg::DIV_W-1:0]    quotient,
    output logic [e2c_pkg::REM_W-1:0]    remainder,
    output logic                         done
);

    localparam int DW = e2c_pkg::DIV_W;
    localparam int RW = e2c_pkg::REM_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic [e2c_pkg::STEP_W-1:0]    cnt_reg;
    logic [DW-1:0]                 quo_reg;
    logic [RW-1:0]                 rem_reg;
    logic [RW-1:0]                 dvs_reg;
    logic [DW+RW-1:0]              mid;
    logic [DW+RW-1:0]              quorem_next;

    function automatic logic [DW+RW-1:0] div_step(input logic [RW-1:0] r,
                                                  input logic [DW-1:0] q,
                                                  input logic [RW-1:0] d);
        logic [RW:0] t;
        logic        qbit;
        t    = {r, q[DW-1]};
        qbit = 1'b0;
        if (t >= {1'b0, d}) begin
            t    = t - {1'b0, d};
            qbit = 1'b1;
        end
        return {t[RW-1:0], q[DW-2:0], qbit};
    endfunction

    always_comb begin
        mid         = div_step(rem_reg, quo_reg, dvs_reg);
        quorem_next = div_step(mid[DW+RW-1:DW], mid[DW-1:0], dvs_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == e2c_pkg::STEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - e2c_pkg::STEP_W'(1);
                if (cnt_reg == e2c_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quorem_next[DW-1:0];
            rem_reg <= quorem_next[DW+RW-1:DW];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    `E2C_ASSERT(a_start_when_idle, aclk, aresetn, start |-> !busy_reg)
    `E2C_ASSERT(a_partial_rem_bound, aclk, aresetn, busy_reg |-> (rem_reg < dvs_reg))
    `E2C_ASSERT_NEXT(a_done_single, aclk, aresetn, done_reg, !done_reg && !busy_reg)

endmodule

// ===== rtl/e2c_dp.sv =====
// Datapath: zone register, range checks, divider operand muxing, date fields, output register
module e2c_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [19:0]          cfg_wr_data,
    input  logic [63:0]          s_tdata,
    input  e2c_pkg::cmd_t        cmd,
    output e2c_pkg::stat_t       stat,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [71:0]          m_tdata,
    output logic                 m_tuser
);

    localparam int DW = e2c_pkg::DIV_W;
    localparam int RW = e2c_pkg::REM_W;
    localparam logic signed [35:0] QC_BIAS = 36'sd1 <<< e2c_pkg::QC_BIAS_LOG2;

    logic signed [19:0]         zone_reg;
    logic signed [63:0]         t_reg;
    logic signed [63:0]         s_reg;
    logic                       big_reg;
    logic                       ovf_reg;
    logic [40:0]                dayk_reg;
    logic [23:0]                qcm_reg;
    logic [RW-1:0]              rdays_reg;
    logic [16:0]                secs_reg;
    logic [2:0]                 wday_reg;
    logic [1:0]                 c_reg;
    logic [4:0]                 q_reg;
    logic [1:0]                 ry_reg;
    logic [4:0]                 hour_reg;
    logic [5:0]                 min_reg;
    logic [5:0]                 sec_reg;
    logic signed [35:0]         years_reg;
    logic [8:0]                 yday_reg;
    logic [3:0]                 mon_reg;
    logic                       m_tvalid_reg;
    logic [71:0]                m_tdata_reg;
    logic                       m_tuser_reg;

    logic [63:0]                sec_sum;
    logic [DW-1:0]              dvd;
    logic [RW-1:0]              dvs;
    logic [e2c_pkg::STEP_W-1:0] stp;
    logic [DW-1:0]              quo;
    logic [RW-1:0]              rem;
    logic                       div_done;
    logic [3:0]                 wsum;
    logic                       leap;
    logic [9:0]                 yd_raw;
    logic [9:0]                 yd_lim;
    logic signed [35:0]         qc_ext;
    logic signed [35:0]         years_calc;
    logic [4:0]                 mlen;
    logic                       month_done;
    logic                       wrap;
    logic [3:0]                 mon_out;
    logic signed [35:0]         year_fin;
    logic                       ovf_fin;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg <= '0;
        end else if (cfg_wr_en) begin
            zone_reg <= cfg_wr_data;
        end
    end

    // ---------------- divider operands ----------------
    assign sec_sum = s_reg + e2c_pkg::SEC_OFFSET;

    always_comb begin
        case (cmd.div_op)
            e2c_pkg::OP_SEC: begin
                dvd = sec_sum[DW-1:0];
                dvs = e2c_pkg::SEC_DAY;
                stp = 5'd29;
            end
            e2c_pkg::OP_DAY400: begin
                dvd = {1'b0, dayk_reg, 16'd0};
                dvs = e2c_pkg::DAYS_400Y;
                stp = 5'd21;
            end
            e2c_pkg::OP_WDAY: begin
                dvd = {rdays_reg, 40'd0};
                dvs = e2c_pkg::DAYS_WEEK;
                stp = 5'd9;
            end
            e2c_pkg::OP_C100: begin
                dvd = {rdays_reg, 40'd0};
                dvs = e2c_pkg::DAYS_100Y;
                stp = 5'd9;
            end
            e2c_pkg::OP_Q4: begin
                dvd = {rdays_reg[15:0], 42'd0};
                dvs = e2c_pkg::DAYS_4Y;
                stp = 5'd8;
            end
            e2c_pkg::OP_RY: begin
                dvd = {rdays_reg[11:0], 46'd0};
                dvs = e2c_pkg::DAYS_1Y;
                stp = 5'd6;
            end
            e2c_pkg::OP_HOUR: begin
                dvd = {1'b0, secs_reg, 40'd0};
                dvs = e2c_pkg::SEC_HOUR;
                stp = 5'd9;
            end
            e2c_pkg::OP_MIN: begin
                dvd = {secs_reg[11:0], 46'd0};
                dvs = e2c_pkg::SEC_MIN;
                stp = 5'd6;
            end
            default: begin
                dvd = '0;
                dvs = e2c_pkg::SEC_MIN;
                stp = 5'd1;
            end
        endcase
    end

    e2c_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_go),
        .dividend  (dvd),
        .divisor   (dvs),
        .steps     (stp),
        .quotient  (quo),
        .remainder (rem),
        .done      (div_done)
    );

    // ---------------- derived fields ----------------
    assign wsum = {1'b0, rem[2:0]} + 4'd3;

    assign leap   = (ry_reg == 2'd0) && ((q_reg != 5'd0) || (c_reg == 2'd0));
    assign yd_raw = {1'b0, rdays_reg[8:0]} + 10'd59 + {9'd0, leap};
    assign yd_lim = 10'd365 + {9'd0, leap};

    assign qc_ext     = $signed({12'd0, qcm_reg}) - QC_BIAS;
    assign years_calc = qc_ext * 36'sd400
                      + $signed({34'd0, c_reg}) * 36'sd100
                      + $signed({31'd0, q_reg}) * 36'sd4
                      + $signed({34'd0, ry_reg});

    assign mlen       = e2c_pkg::month_len(mon_reg);
    assign month_done = (mon_reg == 4'd11) || ({13'd0, mlen} > rdays_reg);

    // January and February belong to the following year
    assign wrap     = (mon_reg >= 4'd10);
    assign mon_out  = wrap ? (mon_reg - 4'd10) : (mon_reg + 4'd2);
    assign year_fin = years_reg + 36'sd100 + (wrap ? 36'sd1 : 36'sd0);
    assign ovf_fin  = ovf_reg || (year_fin > e2c_pkg::Y_MAX) || (year_fin < e2c_pkg::Y_MIN);

    // ---------------- working registers ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            t_reg <= s_tdata;
        end
        if (cmd.calc_s) begin
            s_reg   <= t_reg - 64'(zone_reg);
            big_reg <= (t_reg > e2c_pkg::T_MAX) || (t_reg < e2c_pkg::T_MIN);
        end
        if (cmd.calc_year) begin
            years_reg <= years_calc;
            yday_reg  <= (yd_raw >= yd_lim) ? 9'(yd_raw - yd_lim) : yd_raw[8:0];
            mon_reg   <= 4'd0;
        end
        if (cmd.month_step && !month_done) begin
            rdays_reg <= rdays_reg - {13'd0, mlen};
            mon_reg   <= mon_reg + 4'd1;
        end
        if (cmd.div_store) begin
            case (cmd.div_op)
                e2c_pkg::OP_SEC: begin
                    dayk_reg <= quo[40:0];
                    secs_reg <= rem[16:0];
                end
                e2c_pkg::OP_DAY400: begin
                    qcm_reg   <= quo[23:0];
                    rdays_reg <= rem;
                end
                e2c_pkg::OP_WDAY: begin
                    wday_reg <= (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
                end
                e2c_pkg::OP_C100: begin
                    // last day of a 400-year cycle stays in the fourth century
                    if (quo[2:0] == 3'd4) begin
                        c_reg     <= 2'd3;
                        rdays_reg <= e2c_pkg::DAYS_100Y;
                    end else begin
                        c_reg     <= quo[1:0];
                        rdays_reg <= rem;
                    end
                end
                e2c_pkg::OP_Q4: begin
                    if (quo[4:0] == 5'd25) begin
                        q_reg     <= 5'd24;
                        rdays_reg <= rem + e2c_pkg::DAYS_4Y;
                    end else begin
                        q_reg     <= quo[4:0];
                        rdays_reg <= rem;
                    end
                end
                e2c_pkg::OP_RY: begin
                    // leap day at the end of a 4-year cycle
                    if (quo[2:0] == 3'd4) begin
                        ry_reg    <= 2'd3;
                        rdays_reg <= rem + e2c_pkg::DAYS_1Y;
                    end else begin
                        ry_reg    <= quo[1:0];
                        rdays_reg <= rem;
                    end
                end
                e2c_pkg::OP_HOUR: begin
                    hour_reg <= quo[4:0];
                    secs_reg <= rem[16:0];
                end
                e2c_pkg::OP_MIN: begin
                    min_reg <= quo[5:0];
                    sec_reg <= rem[5:0];
                end
                default: begin
                    sec_reg <= sec_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg <= 1'b0;
        end else if (cmd.load_in) begin
            ovf_reg <= 1'b0;
        end else if (cmd.check) begin
            ovf_reg <= big_reg || (s_reg > e2c_pkg::S_MAX) || (s_reg < e2c_pkg::S_MIN);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tuser_reg <= ovf_fin;
            if (ovf_fin) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {2'd0, sec_reg, min_reg, hour_reg, yday_reg, wday_reg,
                                5'(rdays_reg + 18'd1), mon_out, year_fin[31:0]};
            end
        end
    end

    assign stat.ovf        = ovf_reg;
    assign stat.div_done   = div_done;
    assign stat.month_done = month_done;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/e2c_ctrl.sv =====
// Controller: sequences range checks, divider operations, month walk and result transfer
module e2c_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  e2c_pkg::stat_t   stat,
    output e2c_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUB   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DGO   = 3'd3;
    localparam logic [2:0] ST_DRUN  = 3'd4;
    localparam logic [2:0] ST_YEAR  = 3'd5;
    localparam logic [2:0] ST_MONTH = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [e2c_pkg::OP_W-1:0]    op_reg, op_next;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.div_op = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SUB;
                end
            end
            ST_SUB: begin
                cmd.calc_s = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                op_next    = e2c_pkg::OP_SEC;
                state_next = ST_DGO;
            end
            ST_DGO: begin
                if (stat.ovf) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.div_go = 1'b1;
                    state_next = ST_DRUN;
                end
            end
            ST_DRUN: begin
                if (stat.div_done) begin
                    cmd.div_store = 1'b1;
                    if (op_reg == e2c_pkg::OP_LAST) begin
                        state_next = ST_YEAR;
                    end else begin
                        op_next    = op_reg + e2c_pkg::OP_W'(1);
                        state_next = ST_DGO;
                    end
                end
            end
            ST_YEAR: begin
                cmd.calc_year = 1'b1;
                state_next    = ST_MONTH;
            end
            ST_MONTH: begin
                if (stat.month_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= e2c_pkg::OP_SEC;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ===== rtl/epoch_seconds_to_calendar_top.sv =====
// Top level: epoch seconds to calendar date converter (stream in, stream out, one zone register)
// An input out of range skips the divider and goes straight to the result register.
// One item at a time: the shared radix-4 divider runs eight constant divisions (97 steps),
// then the month walk steps through the month lengths.
// The output register holds a finished result while the next input transfer is taken.
// Reset (aresetn low, synchronous): controller idle, output empty, zone_offset cleared to 0.
module epoch_seconds_to_calendar_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [19:0] cfg_wr_data,   // zone_offset, signed
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // [63:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] years_since_1900, [35:32] month, [40:36] day_of_month, [43:41] weekday,
    // [52:44] day_of_year, [57:53] hour, [63:58] minute, [69:64] second, [71:70] zero
    output logic [71:0] m_tdata,
    output logic        m_tuser        // [0] overflow
);

    e2c_pkg::cmd_t  cmd;
    e2c_pkg::stat_t stat;

    e2c_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    e2c_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== tb/epoch_seconds_to_calendar_checker.sv =====
// Checker for the calendar converter: predicts each result from the input transfers and compares
module epoch_seconds_to_calendar_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [19:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending
);

    // same bit order as {m_tuser, m_tdata}
    typedef struct packed {
        logic        ovf;
        logic [1:0]  pad;
        logic [5:0]  secs;
        logic [5:0]  mins;
        logic [4:0]  hr;
        logic [8:0]  yday;
        logic [2:0]  wday;
        logic [4:0]  mday;
        logic [3:0]  mon;
        logic [31:0] yrs;
    } calendar_rec_t;

    localparam longint SAFE_SPAN  = 64'sh4000_0000_0000_0000;
    localparam longint SPAN_MAX   = 64'sd2147483647 * 64'sd31622400;
    localparam longint SPAN_MIN   = -(64'sd2147483648 * 64'sd31622400);
    localparam longint MARCH_2000 = 64'sd951868800;
    localparam longint YEAR_MAX   = 64'sd2147483647;
    localparam longint YEAR_MIN   = -64'sd2147483648;
    // month lengths, March first
    localparam logic [0:11][4:0] MONTH_DAYS = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
                                               5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd29};

    logic signed [19:0] zone_offset;
    calendar_rec_t      calendar_q[$];
    int                 shown;

    function automatic calendar_rec_t calendar_of(input logic [63:0] raw,
                                                  input logic signed [19:0] zone);
        longint t, secs, days, sod, wd, era, doe, cent, quad, yr, yrs, leap, yd;
        int mon;
        calendar_rec_t r;
        r = '0;
        t = raw;
        if (t < -SAFE_SPAN || t > SAFE_SPAN) begin
            r.ovf = 1'b1;
            return r;
        end
        t = t - longint'(zone);
        if (t < SPAN_MIN || t > SPAN_MAX) begin
            r.ovf = 1'b1;
            return r;
        end
        secs = t - MARCH_2000;
        days = secs / 86400;
        sod  = secs % 86400;
        if (sod < 0) begin
            sod  += 86400;
            days -= 1;
        end
        wd = (days + 3) % 7;
        if (wd < 0) wd += 7;
        era = days / 146097;
        doe = days % 146097;
        if (doe < 0) begin
            doe += 146097;
            era -= 1;
        end
        cent = doe / 36524;
        if (cent == 4) cent = 3;
        doe -= cent * 36524;
        quad = doe / 1461;
        if (quad == 25) quad = 24;
        doe -= quad * 1461;
        yr = doe / 365;
        if (yr == 4) yr = 3;
        doe -= yr * 365;
        leap = (yr == 0 && (quad != 0 || cent == 0)) ? 1 : 0;
        yd = doe + 59 + leap;
        if (yd >= 365 + leap) yd -= 365 + leap;
        yrs = yr + 4 * quad + 100 * cent + 400 * era;
        mon = 0;
        while (mon < 11 && longint'(MONTH_DAYS[mon]) <= doe) begin
            doe -= longint'(MONTH_DAYS[mon]);
            mon++;
        end
        // January and February belong to the next year
        if (mon >= 10) begin
            mon -= 12;
            yrs += 1;
        end
        yrs += 100;
        if (yrs > YEAR_MAX || yrs < YEAR_MIN) begin
            r.ovf = 1'b1;
            return r;
        end
        r.yrs  = yrs[31:0];
        r.mon  = 4'(mon + 2);
        r.mday = 5'(doe + 1);
        r.wday = 3'(wd);
        r.yday = 9'(yd);
        r.hr   = 5'(sod / 3600);
        r.mins = 6'((sod / 60) % 60);
        r.secs = 6'(sod % 60);
        return r;
    endfunction

    task automatic note_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got, inout bit bad);
        if (want !== got) begin
            if (shown < 10) begin
                $display("%s mismatch: expected %0h, got %0h", fname, want, got);
                shown++;
            end
            bad = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        calendar_rec_t want, got;
        bit bad;
        if (!aresetn) begin
            zone_offset <= '0;
            calendar_q.delete();
            fail_count  <= 0;
            pending     <= 0;
            shown       = 0;
        end else begin
            if (cfg_wr_en) zone_offset <= cfg_wr_data;
            if (s_tvalid && s_tready) calendar_q.push_back(calendar_of(s_tdata, zone_offset));
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (calendar_q.size() == 0) begin
                    if (shown < 10) begin
                        $display("unexpected result transfer: %0h", got);
                        shown++;
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    want = calendar_q.pop_front();
                    bad  = 1'b0;
                    note_field("overflow", 32'(want.ovf), 32'(got.ovf), bad);
                    note_field("pad", 32'(want.pad), 32'(got.pad), bad);
                    note_field("years_since_1900", want.yrs, got.yrs, bad);
                    note_field("month", 32'(want.mon), 32'(got.mon), bad);
                    note_field("day_of_month", 32'(want.mday), 32'(got.mday), bad);
                    note_field("weekday", 32'(want.wday), 32'(got.wday), bad);
                    note_field("day_of_year", 32'(want.yday), 32'(got.yday), bad);
                    note_field("hour", 32'(want.hr), 32'(got.hr), bad);
                    note_field("minute", 32'(want.mins), 32'(got.mins), bad);
                    note_field("second", 32'(want.secs), 32'(got.secs), bad);
                    if (bad) fail_count <= fail_count + 1;
                end
            end
            pending <= calendar_q.size();
        end
    end

endmodule

// ===== tb/tb_epoch_seconds_to_calendar_top.sv =====
// Testbench top for the calendar converter: clock, reset, stimulus, zone settings and verdict
module tb_epoch_seconds_to_calendar_top;

    localparam longint SAFE_SPAN  = 64'sh4000_0000_0000_0000;
    localparam longint SPAN_MAX   = 64'sd2147483647 * 64'sd31622400;
    localparam longint SPAN_MIN   = -(64'sd2147483648 * 64'sd31622400);
    localparam int     IDLE_LIMIT = 2000;
    localparam int     PHASES     = 8;
    localparam int     PER_PHASE  = 225;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [19:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          send_gap_max = 3;
    int          recv_gap_max = 3;
    longint      hi_edge;   // first second whose year no longer fits
    longint      lo_edge;   // first second of the lowest year that fits

    epoch_seconds_to_calendar_top uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    epoch_seconds_to_calendar_checker calendar_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b != 0) && ((a < 0) != (b < 0))) q -= 1;
        return q;
    endfunction

    // days from 1970-01-01 to January 1 of year y, proleptic Gregorian
    function automatic longint days_to_jan1(input longint y);
        return 365 * (y - 1970) + floor_div(y - 1, 4) - floor_div(y - 1, 100)
               + floor_div(y - 1, 400) - 477;
    endfunction

    function automatic logic [63:0] pick_epoch(input logic signed [19:0] zone);
        int     kind;
        longint base, delta;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            base = longint'($signed($urandom));
        end else if (kind < 45) begin
            base = longint'({$urandom, $urandom}) >>> 23;
        end else if (kind < 60) begin
            // around midnight of a random day
            base = (longint'($signed($urandom)) >>> 8) * 86400 + longint'(zone)
                   + longint'($urandom_range(0, 2)) - 1;
        end else if (kind < 75) begin
            case ($urandom_range(0, 5))
                0:       base = hi_edge + longint'(zone);
                1:       base = lo_edge + longint'(zone);
                2:       base = SPAN_MAX + longint'(zone);
                3:       base = SPAN_MIN + longint'(zone);
                4:       base = SAFE_SPAN;
                default: base = -SAFE_SPAN;
            endcase
            if ($urandom_range(0, 1) != 0) delta = longint'($urandom_range(0, 6)) - 3;
            else delta = longint'($signed($urandom)) >>> 15;
            base = base + delta;
        end else if (kind < 88) begin
            base = longint'({$urandom, $urandom});
        end else begin
            base = longint'({$urandom, $urandom}) >>> $urandom_range(0, 63);
        end
        return base;
    endfunction

    task automatic send_epoch(input logic [63:0] value);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // result side: random stall before each result
    initial begin
        int stall, taken;
        taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 40 == 0) recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            stall = $urandom_range(0, recv_gap_max);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0]        directed[$];
        logic signed [19:0] cur_zone;
        int                 ph, n;

        hi_edge = days_to_jan1(64'sd2147485548) * 86400;
        lo_edge = days_to_jan1(-64'sd2147481748) * 86400;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zone is zero after reset: calendar corners, leap days, range edges
        directed = '{64'd0, -64'sd1, 64'd86399, 64'd86400, 64'd951782400, 64'd951868800,
                     64'd978307199, -64'sd2203891200, -64'sd2208988800,
                     64'sd2147483647, -64'sd2147483648,
                     64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                     SAFE_SPAN, SAFE_SPAN + 1, -SAFE_SPAN, -SAFE_SPAN - 1,
                     SPAN_MAX, SPAN_MAX + 1, SPAN_MIN, SPAN_MIN - 1,
                     hi_edge - 1, hi_edge, lo_edge, lo_edge - 1};
        foreach (directed[i]) send_epoch(directed[i]);

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0:       cur_zone = 20'sd358799;
                1:       cur_zone = -20'sd358799;
                2:       cur_zone = 20'h7FFFF;
                3:       cur_zone = 20'h80000;
                4:       cur_zone = '0;
                default: cur_zone = 20'($urandom);
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= cur_zone;
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
            @(posedge aclk);
            for (n = 0; n < PER_PHASE; n++) begin
                if (n % 40 == 0) send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
                send_epoch(pick_epoch(cur_zone));
            end
        end

        drain();
        repeat (140) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/e2c_pkg.sv
rtl/e2c_div.sv
rtl/e2c_dp.sv
rtl/e2c_ctrl.sv
rtl/epoch_seconds_to_calendar_top.sv
tb/epoch_seconds_to_calendar_checker.sv
tb/tb_epoch_seconds_to_calendar_top.sv
